@@ rtl/core/sclp_pkg.sv @@
`timescale 1ns / 1ps

package sclp_pkg;

    // default depth of the line store
    localparam int LINE_LEN_DEF = 32;

    // characters of the command syntax
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_CMD      = 8'h44;  // 'D'
    localparam logic [7:0] CH_ANGLE    = 8'h41;  // 'A'
    localparam logic [7:0] CH_GAIN_P   = 8'h70;  // 'p'
    localparam logic [7:0] CH_GAIN_I   = 8'h69;  // 'i'
    localparam logic [7:0] CH_GAIN_D   = 8'h64;  // 'd'
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_HEX   = 8'd55;  // 'A' - 10

    // configuration reset values and register indexes
    localparam logic [15:0] PULSE_BASE_RST = 16'd500;
    localparam logic [9:0]  MAX_ANGLE_RST  = 10'd180;
    localparam logic        CFG_PULSE_BASE = 1'b0;
    localparam logic        CFG_MAX_ANGLE  = 1'b1;

    // gain limit and divide-by-nine reciprocal (exact for values below 2^17)
    localparam int          GAIN_MAX     = 999;
    localparam int          ANGLE_SCALE  = 100;
    localparam logic [16:0] RECIP_9      = 17'd116509;
    localparam int          RECIP_SHIFT  = 20;

    // number of hex characters in a pulse echo
    localparam int HEX_DIGITS = 8;

    // result kinds
    localparam logic KIND_HEX    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ANGLE,
        CMD_P,
        CMD_I,
        CMD_D
    } sclp_cmd_t;

    // request from parser to emitter
    typedef struct packed {
        logic start;
        logic kind;
    } sclp_emit_req_t;

    // current pulse and gains
    typedef struct packed {
        logic [15:0] pulse;
        logic [9:0]  kp;
        logic [9:0]  ki;
        logic [9:0]  kd;
    } sclp_vals_t;

    // upper-case ascii hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
            return ASCII_ZERO + wide;
        else
            return ASCII_HEX + wide;
    endfunction

endpackage

@@ rtl/core/sclp_line_store.sv @@
`timescale 1ns / 1ps

module sclp_line_store
    import sclp_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF,
    localparam int AW = $clog2(LINE_LEN)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [LINE_LEN];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sclp_parser.sv @@
`timescale 1ns / 1ps

module sclp_parser
    import sclp_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF,
    localparam int AW = $clog2(LINE_LEN),
    localparam int FW = $clog2(LINE_LEN + 1)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     rx_byte,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data,
    output logic           mem_we,
    output logic [AW-1:0]  mem_waddr,
    output logic [7:0]     mem_wdata,
    output logic [AW-1:0]  mem_raddr,
    input  logic [7:0]     mem_rdata,
    input  logic           emit_busy,
    output sclp_emit_req_t emit_req,
    output sclp_vals_t     vals
);

    typedef enum logic [5:0] {
        S_FILL   = 6'b000001,
        S_READ   = 6'b000010,
        S_CALC   = 6'b000100,
        S_SCALE  = 6'b001000,
        S_MUL    = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    localparam int NCAP = 6;

    state_t             state_reg, state_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      len_reg, len_next;
    logic [2:0]         rd_cnt_reg, rd_cnt_next;
    logic [7:0]         cap_reg [NCAP];
    sclp_cmd_t          cmd_reg, cmd_next;
    logic signed [15:0] v_reg;
    logic               ok_reg;
    logic [16:0]        x_reg;
    logic [15:0]        cand_reg;
    logic [15:0]        pulse_reg;
    logic [9:0]         kp_reg, ki_reg, kd_reg;
    logic [15:0]        pulse_base_reg;
    logic [9:0]         max_angle_reg;

    logic               accept;
    logic               room;
    logic [2:0]         cap_idx;
    logic [7:0]         cap_byte;
    logic signed [15:0] d2, d3, d4, d5, db, dc, v_calc;
    logic [33:0]        prod;
    logic               commit;

    assign in_ready = (state_reg == S_FILL);
    assign accept   = in_valid && in_ready;
    assign room     = (fill_reg < FW'(LINE_LEN));

    // line store write at the fill position
    assign mem_we    = accept && room;
    assign mem_waddr = fill_reg[AW-1:0];
    assign mem_wdata = rx_byte;
    assign mem_raddr = AW'(rd_cnt_reg);

    // read data arrives in the cycle after its address; unwritten places read zero
    assign cap_idx  = rd_cnt_reg - 3'd1;
    assign cap_byte = (FW'(cap_idx) < len_reg) ? mem_rdata : 8'h00;

    // digit values of the captured characters
    function automatic logic signed [15:0] digit(input logic [7:0] ch);
        return $signed({8'h00, ch}) - $signed({8'h00, ASCII_ZERO});
    endfunction

    assign d2 = digit(cap_reg[2]);
    assign d3 = digit(cap_reg[3]);
    assign d4 = digit(cap_reg[4]);
    assign d5 = digit(cap_reg[5]);
    assign db = (cmd_next == CMD_I) ? d4 : d3;
    assign dc = (cmd_next == CMD_ANGLE) ? d4 : d5;
    assign v_calc = d2 * 16'sd100 + db * 16'sd10 + dc;

    // command decode from the first two characters
    always_comb
    begin
        cmd_next = CMD_NONE;
        if (cap_reg[0] == CH_CMD)
        begin
            unique case (cap_reg[1])
                CH_ANGLE:  cmd_next = CMD_ANGLE;
                CH_GAIN_P: cmd_next = CMD_P;
                CH_GAIN_I: cmd_next = CMD_I;
                CH_GAIN_D: cmd_next = CMD_D;
                default:   cmd_next = CMD_NONE;
            endcase
        end
    end

    // scaled angle divided by nine
    assign prod   = 34'(x_reg) * 34'(RECIP_9);
    assign commit = (state_reg == S_COMMIT) && !emit_busy;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            S_FILL:
            begin
                if (accept)
                begin
                    fill_next = room ? fill_reg + FW'(1) : fill_reg;
                    if (rx_byte == CH_NEWLINE)
                    begin
                        len_next    = fill_next;
                        fill_next   = '0;
                        rd_cnt_next = '0;
                        state_next  = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'(NCAP))
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = (cmd_next == CMD_NONE) ? S_FILL : S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    state_next = S_FILL;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            fill_reg   <= '0;
            len_reg    <= '0;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // capture shift line: the first character ends up at place zero
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_READ) && (rd_cnt_reg != 3'd0))
        begin
            for (int k = 0; k < NCAP - 1; k++)
            begin
                cap_reg[k] <= cap_reg[k+1];
            end
            cap_reg[NCAP-1] <= cap_byte;
        end
    end

    // arithmetic pipeline of the parse
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            cmd_reg <= cmd_next;
            v_reg   <= v_calc;
        end
        if (state_reg == S_SCALE)
        begin
            if (cmd_reg == CMD_ANGLE)
                ok_reg <= !v_reg[15] && (v_reg[14:0] <= 15'(max_angle_reg));
            else
                ok_reg <= !v_reg[15] && (v_reg[14:0] <= 15'(GAIN_MAX));
            x_reg <= 17'(v_reg[9:0]) * 17'(ANGLE_SCALE);
        end
        if (state_reg == S_MUL)
        begin
            cand_reg <= pulse_base_reg + 16'(prod >> RECIP_SHIFT);
        end
    end

    // pulse, gains and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg      <= '0;
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            pulse_base_reg <= PULSE_BASE_RST;
            max_angle_reg  <= MAX_ANGLE_RST;
        end
        else
        begin
            if (commit && ok_reg)
            begin
                case (cmd_reg)
                    CMD_ANGLE: pulse_reg <= cand_reg;
                    CMD_P:     kp_reg    <= v_reg[9:0];
                    CMD_I:     ki_reg    <= v_reg[9:0];
                    CMD_D:     kd_reg    <= v_reg[9:0];
                    default:   ;
                endcase
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PULSE_BASE: pulse_base_reg <= cfg_data;
                    CFG_MAX_ANGLE:  max_angle_reg  <= cfg_data[9:0];
                    default:        ;
                endcase
            end
        end
    end

    assign emit_req.start = commit;
    assign emit_req.kind  = (cmd_reg == CMD_ANGLE) ? KIND_HEX : KIND_REPORT;

    assign vals.pulse = pulse_reg;
    assign vals.kp    = kp_reg;
    assign vals.ki    = ki_reg;
    assign vals.kd    = kd_reg;

endmodule

@@ rtl/core/sclp_emitter.sv @@
`timescale 1ns / 1ps

module sclp_emitter
    import sclp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  sclp_emit_req_t emit_req,
    input  sclp_vals_t     vals,
    output logic           emit_busy,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           kind,
    output logic [7:0]     out_char,
    output logic [15:0]    pulse,
    output logic [9:0]     kp_tenths,
    output logic [9:0]     ki_hundredths,
    output logic [9:0]     kd_tenths,
    output logic           last
);

    localparam logic [2:0] LAST_DIGIT = 3'(HEX_DIGITS - 1);

    logic       valid_reg;
    logic       kind_reg;
    logic [2:0] cnt_reg;
    logic [3:0] nib;

    // pick the nibble: the upper four characters are always zero
    always_comb
    begin
        nib = 4'h0;
        if (cnt_reg[2])
        begin
            case (cnt_reg[1:0])
                2'd0:    nib = vals.pulse[15:12];
                2'd1:    nib = vals.pulse[11:8];
                2'd2:    nib = vals.pulse[7:4];
                default: nib = vals.pulse[3:0];
            endcase
        end
    end

    assign last = (kind_reg == KIND_REPORT) || (cnt_reg == LAST_DIGIT);

    // item sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kind_reg  <= KIND_HEX;
            cnt_reg   <= '0;
        end
        else if (emit_req.start)
        begin
            valid_reg <= 1'b1;
            kind_reg  <= emit_req.kind;
            cnt_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
                valid_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 3'd1;
        end
    end

    assign emit_busy     = valid_reg;
    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign out_char      = (kind_reg == KIND_REPORT) ? 8'h00 : hex_char(nib);
    assign pulse         = vals.pulse;
    assign kp_tenths     = vals.kp;
    assign ki_hundredths = vals.ki;
    assign kd_tenths     = vals.kd;

endmodule

@@ rtl/core/serial_command_line_parser.sv @@
`timescale 1ns / 1ps

// channel   signals                                        direction
// input     in_valid, in_ready, rx_byte                    item in
// output    out_valid, out_ready, kind, out_char, pulse,   item out
//           kp_tenths, ki_hundredths, kd_tenths, last
// config    cfg_we, cfg_index, cfg_data                    write only
//
// Ordinary bytes are taken back to back, also while an echo drains.
// A newline holds in_ready low while the first six places of the line store are
// read through its one read port and the line is decoded; on a command it then
// stays low to range check, scale by 100/9 and commit, and the commit waits
// until the previous echo is taken.
// An echo is 8 items and a report 1 item, at most one item per cycle.
// Reset needs no clearing pass: the fill count masks unwritten places as zero.

module serial_command_line_parser
    import sclp_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  out_char,
    output logic [15:0] pulse,
    output logic [9:0]  kp_tenths,
    output logic [9:0]  ki_hundredths,
    output logic [9:0]  kd_tenths,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(LINE_LEN);

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;
    logic           emit_busy;
    sclp_emit_req_t emit_req;
    sclp_vals_t     vals;

    // line store
    sclp_line_store #(
        .LINE_LEN (LINE_LEN)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // fill, parse and state update
    sclp_parser #(
        .LINE_LEN (LINE_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .emit_busy (emit_busy),
        .emit_req  (emit_req),
        .vals      (vals)
    );

    // result items
    sclp_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit_req      (emit_req),
        .vals          (vals),
        .emit_busy     (emit_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_char      (out_char),
        .pulse         (pulse),
        .kp_tenths     (kp_tenths),
        .ki_hundredths (ki_hundredths),
        .kd_tenths     (kd_tenths),
        .last          (last)
    );

endmodule
